### src/jpeg_frame_size_scanner_defines.svh
// ----------------------------------------------------------------------------
// jpeg frame size scanner assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef JPEG_FRAME_SIZE_SCANNER_DEFINES_SVH
`define JPEG_FRAME_SIZE_SCANNER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define JFSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define JFSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/jfss_pkg.sv
// ----------------------------------------------------------------------------
// jfss_pkg
// types and constants shared by the jpeg frame size scanner modules
// ----------------------------------------------------------------------------
`default_nettype none

package jfss_pkg;

    // parser phases
    localparam logic [3:0] PH_SEARCH = 4'd0;
    localparam logic [3:0] PH_MARKER = 4'd1;
    localparam logic [3:0] PH_LEN_HI = 4'd2;
    localparam logic [3:0] PH_LEN_LO = 4'd3;
    localparam logic [3:0] PH_SKIP   = 4'd4;
    localparam logic [3:0] PH_PREC   = 4'd5;
    localparam logic [3:0] PH_H_HI   = 4'd6;
    localparam logic [3:0] PH_H_LO   = 4'd7;
    localparam logic [3:0] PH_W_HI   = 4'd8;
    localparam logic [3:0] PH_W_LO   = 4'd9;

    // result status codes
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_ZERO_DIM  = 2'd1;
    localparam logic [1:0] ST_EOI       = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    // marker bytes
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF1   = 8'hC1;
    localparam logic [7:0] MK_SOF2   = 8'hC2;

    localparam logic [15:0] SOF_MIN_LEN = 16'd9;

    // status + width + height = 34 bits, padded to 5 bytes
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] height;
        logic [15:0] width;
        logic [1:0]  status;
    } t_result;

endpackage

`default_nettype wire

### src/jfss_in_reg.sv
// ----------------------------------------------------------------------------
// jfss_in_reg
// input register stage holding one byte request for the parser
// ----------------------------------------------------------------------------
`default_nettype none

module jfss_in_reg (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  jfss_pkg::t_in_item i_item,
    output logic              o_valid,
    output jfss_pkg::t_in_item o_item,
    input  wire               i_take
);
    import jfss_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

### src/jfss_parser.sv
// ----------------------------------------------------------------------------
// jfss_parser
// byte-wide marker/segment state machine, one byte per take
// ----------------------------------------------------------------------------
`default_nettype none

module jfss_parser (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_take,
    input  jfss_pkg::t_in_item i_item,
    output logic               o_res_valid,
    output jfss_pkg::t_result  o_res
);
    import jfss_pkg::*;

    logic [3:0]  r_phase,    n_phase;
    logic [7:0]  r_marker,   n_marker;
    logic [15:0] r_seg_len,  n_seg_len;
    logic [15:0] r_skip,     n_skip;
    logic [15:0] r_height,   n_height;
    logic [15:0] r_width,    n_width;
    logic        r_given,    n_given;

    logic [7:0]  b;
    logic [15:0] seg_full;
    logic        is_sof;
    logic        hit;

    assign b        = i_item.data_byte;
    assign seg_full = {r_seg_len[15:8], b};
    assign is_sof   = (r_marker == MK_SOF0) || (r_marker == MK_SOF1) ||
                      (r_marker == MK_SOF2);

    always_comb begin
        n_phase   = r_phase;
        n_marker  = r_marker;
        n_seg_len = r_seg_len;
        n_skip    = r_skip;
        n_height  = r_height;
        n_width   = r_width;
        n_given   = r_given;
        hit       = 1'b0;
        o_res     = '{height: 16'd0, width: 16'd0, status: ST_FOUND};

        if (!r_given) begin
            unique case (r_phase)
                PH_MARKER: begin
                    if (b == MK_SOI) begin
                        n_phase = PH_SEARCH;
                    end else if (b == MK_EOI) begin
                        hit          = 1'b1;
                        o_res.status = ST_EOI;
                    end else begin
                        n_marker = b;
                        n_phase  = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    n_seg_len = {b, 8'd0};
                    n_phase   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_seg_len = seg_full;
                    if (seg_full[15:1] == 15'd0) begin
                        // length cannot even cover itself
                        hit          = 1'b1;
                        o_res.status = ST_EXHAUSTED;
                    end else if (is_sof && seg_full >= SOF_MIN_LEN) begin
                        n_phase = PH_PREC;
                    end else begin
                        n_skip  = seg_full - 16'd2;
                        n_phase = (n_skip != 16'd0) ? PH_SKIP : PH_SEARCH;
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 16'd1;
                    if (n_skip == 16'd0) begin
                        n_phase = PH_SEARCH;
                    end
                end
                PH_PREC: begin
                    n_phase = PH_H_HI;
                end
                PH_H_HI: begin
                    n_height = {b, 8'd0};
                    n_phase  = PH_H_LO;
                end
                PH_H_LO: begin
                    n_height = {r_height[15:8], b};
                    n_phase  = PH_W_HI;
                end
                PH_W_HI: begin
                    n_width = {b, 8'd0};
                    n_phase = PH_W_LO;
                end
                PH_W_LO: begin
                    n_width      = {r_width[15:8], b};
                    hit          = 1'b1;
                    o_res.width  = n_width;
                    o_res.height = r_height;
                    o_res.status = (n_width != 16'd0 && r_height != 16'd0) ?
                                   ST_FOUND : ST_ZERO_DIM;
                end
                default: begin
                    n_phase = (b == MK_PREFIX) ? PH_MARKER : PH_SEARCH;
                end
            endcase
            if (hit) begin
                n_given = 1'b1;
            end
        end

        o_res_valid = hit;
        if (i_item.last_byte && !n_given) begin
            // file ended without an answer
            o_res_valid = 1'b1;
            o_res       = '{height: 16'd0, width: 16'd0, status: ST_EXHAUSTED};
        end

        if (i_item.last_byte) begin
            n_phase   = PH_SEARCH;
            n_marker  = 8'd0;
            n_seg_len = 16'd0;
            n_skip    = 16'd0;
            n_height  = 16'd0;
            n_width   = 16'd0;
            n_given   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEARCH;
            r_marker  <= 8'd0;
            r_seg_len <= 16'd0;
            r_skip    <= 16'd0;
            r_height  <= 16'd0;
            r_width   <= 16'd0;
            r_given   <= 1'b0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_marker  <= n_marker;
            r_seg_len <= n_seg_len;
            r_skip    <= n_skip;
            r_height  <= n_height;
            r_width   <= n_width;
            r_given   <= n_given;
        end
    end

endmodule

`default_nettype wire

### src/jfss_out_reg.sv
// ----------------------------------------------------------------------------
// jfss_out_reg
// result register driving the master-side stream
// ----------------------------------------------------------------------------
`default_nettype none

module jfss_out_reg (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_load,
    input  jfss_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [jfss_pkg::OUT_TDATA_W-1:0] o_tdata
);
    import jfss_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_tdata = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

### src/jpeg_frame_size_scanner.sv
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner
// finds height/width in the first baseline/extended/progressive frame header
// ----------------------------------------------------------------------------
// usage:
//   slave side takes a jpeg file one byte per request, tlast on its final byte
//   master side gives exactly one result request per file:
//     status found, zero dimension, end-of-image before frame header,
//     or data exhausted, together with width and height
//   the byte that decides a result passes the input register, then the parser
//     into the result register
//   throughput: one byte per cycle unless a waiting result blocks it; the parser
//     advances its state in the same cycle it moves the registered byte on
//   the input register refills while a result waits, so a stalled receiver
//     only blocks intake once a second byte would need the parser
//   bytes after a result are swallowed up to tlast; tlast resets the parser
//     so the next byte begins a new file
//   reset (i_rst_n low, synchronous) empties both registers and returns the
//     parser to searching for the 0xff prefix
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_frame_size_scanner (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave side
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire         i_s_axis_tlast,   // last_byte
    // master side
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [jfss_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
    // [1:0] status, [17:2] width, [33:18] height, [39:34] zero
);
    import jfss_pkg::*;

    t_in_item in_item;
    t_in_item reg_item;
    logic     reg_valid;
    logic     take;
    logic     out_free;
    logic     res_valid;
    t_result  res;

    assign in_item = '{last_byte: i_s_axis_tlast, data_byte: i_s_axis_tdata};

    // parser only steps when the result register can absorb a possible result
    assign take = reg_valid && out_free;

    jfss_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .o_item  (reg_item),
        .i_take  (take)
    );

    jfss_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (reg_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    jfss_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_tdata (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

### src/jfss_checker.sv
// ----------------------------------------------------------------------------
// jfss_checker
// port-level checks for the jpeg frame size scanner
// ----------------------------------------------------------------------------
`default_nettype none

`include "jpeg_frame_size_scanner_defines.svh"

module jfss_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_axis_tvalid,
    input wire        o_s_axis_tready,
    input wire [7:0]  i_s_axis_tdata,
    input wire        i_s_axis_tlast,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [jfss_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import jfss_pkg::*;

    logic unused_in;
    logic no_dims;

    assign unused_in = i_s_axis_tvalid ^ o_s_axis_tready ^ (^i_s_axis_tdata) ^
                       i_s_axis_tlast;
    assign no_dims   = (o_m_axis_tdata[1:0] == ST_EOI) ||
                       (o_m_axis_tdata[1:0] == ST_EXHAUSTED);

    // stalled result stays put
    `JFSS_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // no dimensions ride with an eoi or exhausted status
    `JFSS_ASSERT_IMP(a_no_dims, o_m_axis_tvalid && no_dims, o_m_axis_tdata[33:2] == 32'd0 || unused_in != unused_in, "dimensions on a status without frame header")

    // padding above the height field is zero
    `JFSS_ASSERT_IMP(a_pad_zero, o_m_axis_tvalid, o_m_axis_tdata[39:34] == 6'd0, "nonzero tdata padding")

    // nothing is offered right after reset
    `JFSS_ASSERT_IMP(a_rst_empty, !$past(i_rst_n), !o_m_axis_tvalid, "result valid straight out of reset")

endmodule

bind jpeg_frame_size_scanner jfss_checker u_jfss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
